### rtl/tce_pkg.sv
package tce_pkg;

    // mode field codes
    localparam logic [2:0] MODE_PUT    = 3'd0;
    localparam logic [2:0] MODE_SETCUR = 3'd1;
    localparam logic [2:0] MODE_DRAW   = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // control characters
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

    localparam logic [7:0] ATTR_RESET = 8'h07;

    // configuration register indexes
    localparam logic REG_TEXT_COLOR    = 1'b0;
    localparam logic REG_CURSOR_HIDDEN = 1'b1;

    typedef enum logic [3:0] {
        OP_ERROR,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_PRINT,
        OP_SETCUR,
        OP_DRAW,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] attr;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  char_out;
        logic [4:0]  cur_row;
        logic [6:0]  cur_col;
        logic [12:0] hw_cursor_offset;
    } res_t;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

### rtl/tce_ram.sv
module tce_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tce_fifo.sv
module tce_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);

    // two-entry queue
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/tce_front.sv
module tce_front #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept_en,
    input  logic          push,
    output logic          full,
    input  logic [2:0]    mode,
    input  logic [7:0]    byte_in,
    input  logic [7:0]    row_in,
    input  logic [7:0]    col_in,
    input  logic [7:0]    draw_color,
    output logic          cmd_empty,
    input  logic          cmd_pop,
    output tce_pkg::cmd_t cmd
);

    import tce_pkg::*;

    cmd_t dec;
    logic pos_ok;
    logic q_full;
    logic q_push;

    assign pos_ok = ({24'd0, row_in} < ROWS) && ({24'd0, col_in} < COLUMNS);

    always_comb
    begin
        dec.ch   = byte_in;
        dec.row  = row_in;
        dec.col  = col_in;
        dec.attr = draw_color;
        unique case (mode)
            MODE_PUT:
            begin
                priority if (byte_in == CH_NEWLINE)
                    dec.op = OP_NEWLINE;
                else if (byte_in == CH_RETURN)
                    dec.op = OP_RETURN;
                else if (byte_in == CH_BACKSPACE)
                    dec.op = OP_BACKSPACE;
                else if (byte_in >= CH_PRINT_LO && byte_in <= CH_PRINT_HI)
                    dec.op = OP_PRINT;
                else
                    dec.op = OP_ERROR;
            end
            MODE_SETCUR: dec.op = pos_ok ? OP_SETCUR : OP_ERROR;
            MODE_DRAW:   dec.op = pos_ok ? OP_DRAW : OP_ERROR;
            MODE_READ:   dec.op = pos_ok ? OP_READ : OP_ERROR;
            MODE_CLEAR:  dec.op = OP_CLEAR;
            default:     dec.op = OP_ERROR;
        endcase
    end

    assign full   = q_full || !accept_en;
    assign q_push = push && !full;

    tce_fifo #(
        .W(CMD_W)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .full (q_full),
        .wdata(dec),
        .pop  (cmd_pop),
        .empty(cmd_empty),
        .rdata(cmd)
    );

endmodule

### rtl/tce_back.sv
module tce_back #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    text_color,
    input  logic          cursor_hidden,
    output logic          accept_en,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  tce_pkg::cmd_t cmd,
    output logic          res_empty,
    input  logic          res_pop,
    output tce_pkg::res_t res
);

    import tce_pkg::*;

    localparam int N  = ROWS * COLUMNS;
    localparam int AW = $clog2(N);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int HIDDEN_OFF = (COLUMNS * COLUMNS + ROWS) % 8192;

    state_t        state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic          wv_reg, wv_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic          clear_mode_reg, clear_mode_next;
    logic [7:0]    pend_ch_reg, pend_ch_next;

    logic [RW:0]   row_p1;
    logic [CW:0]   col_p1;
    logic          walk_last;
    logic [AW-1:0] walk_src;
    logic          force_space;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic          res_push, res_full;
    logic          res_status;
    logic [7:0]    res_ch;
    res_t          res_in;

    function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
        return AW'(r * COLUMNS + c);
    endfunction

    assign row_p1    = {1'b0, row_reg} + 1'b1;
    assign col_p1    = {1'b0, col_reg} + 1'b1;
    assign walk_last = (widx_reg == AW'(N - 1));

    // scroll copies from one row below; bottom row and clear rewrite in place
    assign walk_src = (clear_mode_reg || ({1'b0, widx_reg} >= (AW+1)'(N - COLUMNS)))
                      ? widx_reg : AW'(widx_reg + COLUMNS);
    assign force_space = clear_mode_reg || ({1'b0, wa_reg} >= (AW+1)'(N - COLUMNS));

    assign accept_en = (state_reg != ST_INIT);

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        widx_next       = widx_reg;
        wv_next         = 1'b0;
        wa_next         = widx_reg;
        clear_mode_next = clear_mode_reg;
        pend_ch_next    = pend_ch_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_status      = 1'b0;
        res_ch          = 8'd0;
        ram_raddr       = walk_src;
        // trailing write of the walk pipeline
        ram_we          = wv_reg;
        ram_waddr       = wa_reg;
        ram_wdata       = {ram_rdata[15:8], force_space ? CH_SPACE : ram_rdata[7:0]};

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = widx_reg;
                ram_wdata = {ATTR_RESET, CH_SPACE};
                if (walk_last)
                begin
                    widx_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    widx_next = widx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop   = 1'b1;
                    widx_next = '0;
                    unique case (cmd.op)
                        OP_SETCUR:
                        begin
                            row_next = RW'(cmd.row);
                            col_next = CW'(cmd.col);
                            res_push = 1'b1;
                        end
                        OP_DRAW:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr(RW'(cmd.row), CW'(cmd.col));
                            ram_wdata = {cmd.attr, cmd.ch};
                            res_push  = 1'b1;
                        end
                        OP_READ:
                        begin
                            ram_raddr  = cell_addr(RW'(cmd.row), CW'(cmd.col));
                            state_next = ST_READ;
                        end
                        OP_PRINT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr(row_reg, col_reg);
                            ram_wdata = {text_color, cmd.ch};
                            res_ch    = cmd.ch;
                            if (col_p1 == (CW+1)'(COLUMNS))
                            begin
                                col_next = '0;
                                if (row_p1 == (RW+1)'(ROWS))
                                begin
                                    clear_mode_next = 1'b0;
                                    pend_ch_next    = cmd.ch;
                                    state_next      = ST_WALK;
                                end
                                else
                                begin
                                    row_next = RW'(row_p1);
                                    res_push = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = CW'(col_p1);
                                res_push = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            res_ch   = cmd.ch;
                            if (row_p1 == (RW+1)'(ROWS))
                            begin
                                clear_mode_next = 1'b0;
                                pend_ch_next    = cmd.ch;
                                state_next      = ST_WALK;
                            end
                            else
                            begin
                                row_next = RW'(row_p1);
                                res_push = 1'b1;
                            end
                        end
                        OP_RETURN:
                        begin
                            col_next = '0;
                            res_ch   = cmd.ch;
                            res_push = 1'b1;
                        end
                        OP_BACKSPACE:
                        begin
                            col_next  = (col_reg == '0) ? '0 : col_reg - 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr(row_reg, col_next);
                            ram_wdata = {text_color, CH_SPACE};
                            res_ch    = cmd.ch;
                            res_push  = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            row_next        = '0;
                            col_next        = '0;
                            clear_mode_next = 1'b1;
                            pend_ch_next    = 8'd0;
                            state_next      = ST_WALK;
                        end
                        default:
                        begin
                            res_status = 1'b1;
                            res_push   = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_ch     = ram_rdata[7:0];
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                wv_next = 1'b1;
                wa_next = widx_reg;
                if (walk_last)
                begin
                    widx_next  = '0;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    widx_next = widx_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                res_ch     = pend_ch_reg;
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_in.status           = res_status;
        res_in.char_out         = res_ch;
        res_in.cur_row          = 5'(row_next);
        res_in.cur_col          = 7'(col_next);
        res_in.hw_cursor_offset = cursor_hidden ? 13'(HIDDEN_OFF)
                                                : 13'(row_next * COLUMNS + col_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            row_reg        <= '0;
            col_reg        <= '0;
            widx_reg       <= '0;
            wv_reg         <= 1'b0;
            clear_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            widx_reg       <= widx_next;
            wv_reg         <= wv_next;
            clear_mode_reg <= clear_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg      <= wa_next;
        pend_ch_reg <= pend_ch_next;
    end

    tce_ram #(
        .W    (16),
        .DEPTH(N)
    ) u_cells (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    tce_fifo #(
        .W(RES_W)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .full (res_full),
        .wdata(res_in),
        .pop  (res_pop),
        .empty(res_empty),
        .rdata(res)
    );

endmodule

### rtl/text_console_engine_top.sv
// Text console engine: ROWS x COLUMNS grid of char/attribute cells plus a cursor.
// Read char takes an extra read state; scroll and clear walk the grid through the cell
// RAM at one cell a cycle. Throughput: one request per cycle into the back end executor,
// bound by one RAM write port, while the result queue has room and no read or walk runs.
// Reset: asynchronous active low; a clearing pass over all ROWS*COLUMNS cells (2000 by
// default) fills the grid with spaces in attribute 0x07, with full held high meanwhile.
module text_console_engine_top #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic        clk,
    input  logic        rst_n,

    // request side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_in,
    input  logic [7:0]  row_in,
    input  logic [7:0]  col_in,
    input  logic [7:0]  draw_color,

    // result side
    output logic        empty,
    input  logic        pop,
    output logic        status,
    output logic [7:0]  char_out,
    output logic [4:0]  cur_row,
    output logic [6:0]  cur_col,
    output logic [12:0] hw_cursor_offset,

    // configuration writes
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    import tce_pkg::*;

    // Configuration registers. The user must write them only while the engine is idle
    // (the block does not enforce it), so the back end can read them directly.
    logic [7:0] text_color_reg;
    logic       cursor_hidden_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg    <= ATTR_RESET;
            cursor_hidden_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_TEXT_COLOR)
            begin
                text_color_reg <= cfg_data;
            end
            else if (cfg_index == REG_CURSOR_HIDDEN)
            begin
                cursor_hidden_reg <= cfg_data[0];
            end
        end
    end

    // Front end: classifies each request (control char, printable,
    // bounds check) and queues it as a command.
    logic accept_en;
    logic cmd_empty;
    logic cmd_pop;
    cmd_t cmd;
    res_t res;

    tce_front #(
        .ROWS   (ROWS),
        .COLUMNS(COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept_en (accept_en),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .byte_in   (byte_in),
        .row_in    (row_in),
        .col_in    (col_in),
        .draw_color(draw_color),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Back end: owns the cell RAM and cursor, executes commands, runs
    // the scroll / clear walks and queues the results.
    tce_back #(
        .ROWS   (ROWS),
        .COLUMNS(COLUMNS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_color   (text_color_reg),
        .cursor_hidden(cursor_hidden_reg),
        .accept_en    (accept_en),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd),
        .res_empty    (empty),
        .res_pop      (pop),
        .res          (res)
    );

    assign status           = res.status;
    assign char_out         = res.char_out;
    assign cur_row          = res.cur_row;
    assign cur_col          = res.cur_col;
    assign hw_cursor_offset = res.hw_cursor_offset;

endmodule

### verif/text_console_engine_checker.sv
module text_console_engine_checker #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_in,
    input  logic [7:0]  row_in,
    input  logic [7:0]  col_in,
    input  logic [7:0]  draw_color,
    input  logic        empty,
    input  logic        pop,
    input  logic        status,
    input  logic [7:0]  char_out,
    input  logic [4:0]  cur_row,
    input  logic [6:0]  cur_col,
    input  logic [12:0] hw_cursor_offset,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          errors,
    output int          outstanding,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import tce_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] ch;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] attr;
    } console_req_t;

    // shadow console: {attr, char} per cell, cursor, registers
    logic [15:0] grid [CELLS];
    int          crow;
    int          ccol;
    logic [7:0]  ink;
    logic        cursor_off;

    res_t        cursor_reports_due [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        checked     = 0;
    end

    function automatic void shadow_reset();
        for (int i = 0; i < CELLS; i++)
            grid[i] = {ATTR_RESET, CH_SPACE};
        crow       = 0;
        ccol       = 0;
        ink        = ATTR_RESET;
        cursor_off = 1'b0;
    endfunction

    // wrap the column, scroll one line when stepping off the bottom row
    function automatic void cursor_move(int r, int c);
        if (c >= COLUMNS)
        begin
            c = 0;
            r = r + 1;
        end
        if (r >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                grid[i] = grid[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                grid[i][7:0] = CH_SPACE;
            r = ROWS - 1;
        end
        crow = r;
        ccol = c;
    endfunction

    function automatic res_t apply_console_request(console_req_t rq);
        res_t rs;
        logic in_grid;
        rs      = '0;
        in_grid = (int'(rq.row) < ROWS) && (int'(rq.col) < COLUMNS);
        case (rq.mode)
            MODE_PUT:
            begin
                rs.char_out = rq.ch;
                if (rq.ch == CH_NEWLINE)
                    cursor_move(crow + 1, 0);
                else if (rq.ch == CH_RETURN)
                    cursor_move(crow, 0);
                else if (rq.ch == CH_BACKSPACE)
                begin
                    cursor_move(crow, (ccol > 0) ? ccol - 1 : 0);
                    grid[crow * COLUMNS + ccol] = {ink, CH_SPACE};
                end
                else if (rq.ch >= CH_PRINT_LO && rq.ch <= CH_PRINT_HI)
                begin
                    grid[crow * COLUMNS + ccol] = {ink, rq.ch};
                    cursor_move(crow, ccol + 1);
                end
                else
                begin
                    rs.status   = 1'b1;
                    rs.char_out = '0;
                end
            end
            MODE_SETCUR:
            begin
                if (in_grid)
                begin
                    crow = int'(rq.row);
                    ccol = int'(rq.col);
                end
                else
                    rs.status = 1'b1;
            end
            MODE_DRAW:
            begin
                if (in_grid)
                    grid[int'(rq.row) * COLUMNS + int'(rq.col)] = {rq.attr, rq.ch};
                else
                    rs.status = 1'b1;
            end
            MODE_READ:
            begin
                if (in_grid)
                    rs.char_out = grid[int'(rq.row) * COLUMNS + int'(rq.col)][7:0];
                else
                    rs.status = 1'b1;
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    grid[i][7:0] = CH_SPACE;
                cursor_move(0, 0);
            end
            default: rs.status = 1'b1;
        endcase
        rs.cur_row = crow[4:0];
        rs.cur_col = ccol[6:0];
        if (cursor_off)
            rs.hw_cursor_offset = 13'(COLUMNS * COLUMNS + ROWS);
        else
            rs.hw_cursor_offset = 13'(crow * COLUMNS + ccol);
        return rs;
    endfunction

    task automatic compare_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            shadow_reset();
            cursor_reports_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (cursor_reports_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual status %0d char %0d",
                             $time, status, char_out);
                end
                else
                begin
                    want = cursor_reports_due.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("char_out", 32'(want.char_out), 32'(char_out));
                    compare_field("cur_row", 32'(want.cur_row), 32'(cur_row));
                    compare_field("cur_col", 32'(want.cur_col), 32'(cur_col));
                    compare_field("hw_cursor_offset", 32'(want.hw_cursor_offset),
                                  32'(hw_cursor_offset));
                    checked++;
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_TEXT_COLOR)
                    ink = cfg_data;
                else if (cfg_index == REG_CURSOR_HIDDEN)
                    cursor_off = cfg_data[0];
            end
            if (push && !full)
                cursor_reports_due.push_back(apply_console_request(
                    '{mode, byte_in, row_in, col_in, draw_color}));
            outstanding <= cursor_reports_due.size();
        end
    end

endmodule

### verif/text_console_engine_top_test.sv
module text_console_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tce_pkg::*;

    localparam int ROWS        = 25;
    localparam int COLUMNS     = 80;
    localparam int HOLD_CYCLES = 400;  // long enough to back the engine up to its input
    localparam int CHUNK       = 55;   // random requests per register setting

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic [2:0]  mode       = MODE_PUT;
    logic [7:0]  byte_in    = '0;
    logic [7:0]  row_in     = '0;
    logic [7:0]  col_in     = '0;
    logic [7:0]  draw_color = '0;
    logic        pop        = 1'b0;
    logic        cfg_write  = 1'b0;
    logic        cfg_index  = REG_TEXT_COLOR;
    logic [7:0]  cfg_data   = '0;

    logic        full;
    logic        empty;
    logic        status;
    logic [7:0]  char_out;
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;
    logic [12:0] hw_cursor_offset;

    int errors;
    int outstanding;
    int checked;

    // idle odds in percent, per side
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold     = 1'b0;
    logic hold_start  = 1'b0;

    int mode_count [8];
    int settings_used = 0;

    always #2 clk = ~clk;

    text_console_engine_top #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .mode             (mode),
        .byte_in          (byte_in),
        .row_in           (row_in),
        .col_in           (col_in),
        .draw_color       (draw_color),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .char_out         (char_out),
        .cur_row          (cur_row),
        .cur_col          (cur_col),
        .hw_cursor_offset (hw_cursor_offset),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    text_console_engine_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_console_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .mode             (mode),
        .byte_in          (byte_in),
        .row_in           (row_in),
        .col_in           (col_in),
        .draw_color       (draw_color),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .char_out         (char_out),
        .cur_row          (cur_row),
        .cur_col          (cur_col),
        .hw_cursor_offset (hw_cursor_offset),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .errors           (errors),
        .outstanding      (outstanding),
        .checked          (checked)
    );

    // result side: random pops, forced off during the hold-off
    always @(posedge clk)
        pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

    // hold-off: receiver stops popping while the sender keeps offering requests
    initial
    begin
        wait (hold_start);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // backstop: covers the reset clearing pass plus every request scrolling,
    // each result delayed by the worst receiver odds, several times over
    initial
    begin
        #20ms;
        $display("text_console_engine_top: mismatch");
        $finish;
    end

    // offer one request after a random gap, hold it until full drops
    task automatic send_request(input logic [2:0] m, input logic [7:0] b,
                                input logic [7:0] r, input logic [7:0] c,
                                input logic [7:0] a);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        mode       <= m;
        byte_in    <= b;
        row_in     <= r;
        col_in     <= c;
        draw_color <= a;
        @(posedge clk);
        while (full) @(posedge clk);
        mode_count[m]++;
    endtask

    // mostly legal console traffic; a slice of out-of-range positions,
    // odd bytes and unused modes
    task automatic send_random_request();
        int         pick;
        int         sub;
        logic [2:0] m;
        logic [7:0] b;
        logic [7:0] r;
        logic [7:0] c;
        logic [7:0] a;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        b    = 8'($urandom);
        r    = 8'($urandom);
        c    = 8'($urandom);
        a    = 8'($urandom);
        if (pick < 45)
        begin
            m = MODE_PUT;
            if (sub < 70)
                b = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
            else if (sub < 80)
                b = CH_NEWLINE;
            else if (sub < 85)
                b = CH_RETURN;
            else if (sub < 93)
                b = CH_BACKSPACE;
        end
        else if (pick < 95)
        begin
            if (pick < 60)
                m = MODE_SETCUR;
            else if (pick < 75)
                m = MODE_DRAW;
            else if (pick < 93)
                m = MODE_READ;
            else
                m = MODE_CLEAR;
            // keep most positions on the grid, leaning on the bottom row
            // and the last column so puts reach the wrap and scroll paths
            if (sub < 85)
            begin
                r = ($urandom_range(0, 3) == 0) ? 8'(ROWS - 1)
                                                : 8'($urandom_range(0, ROWS - 1));
                c = ($urandom_range(0, 4) == 0) ? 8'(COLUMNS - 1)
                                                : 8'($urandom_range(0, COLUMNS - 1));
            end
        end
        else
            m = 3'($urandom_range(MODE_CLEAR + 1, 7));
        send_request(m, b, r, c, a);
    endtask

    // drain: drop push, wait for every result, then a few quiet cycles
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_console_reg(input logic idx, input logic [7:0] data);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n       <= 1'b1;
        tx_idle_pct <= 24;
        rx_idle_pct <= 74;

        // directed: reset contents, every put byte class, cursor edges,
        // wrap and scroll, bad positions, clear and unused modes
        send_request(MODE_READ, 8'h00, 8'd0, 8'd0, 8'h00);
        send_request(MODE_PUT, 8'h41, 8'hFF, 8'hFF, 8'hFF);
        send_request(MODE_PUT, CH_PRINT_LO, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, CH_PRINT_HI, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, 8'h7F, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, 8'h1F, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, CH_BACKSPACE, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, CH_RETURN, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, CH_BACKSPACE, 8'h00, 8'h00, 8'h00);
        send_request(MODE_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00);
        // last cell: print wraps past the bottom and scrolls
        send_request(MODE_SETCUR, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00);
        send_request(MODE_PUT, 8'h5A, 8'h00, 8'h00, 8'h00);
        send_request(MODE_SETCUR, 8'h00, 8'(ROWS - 1), 8'd5, 8'h00);
        send_request(MODE_PUT, CH_NEWLINE, 8'h00, 8'h00, 8'h00);
        send_request(MODE_SETCUR, 8'h00, 8'(ROWS), 8'd0, 8'h00);
        send_request(MODE_SETCUR, 8'h00, 8'd0, 8'(COLUMNS), 8'h00);
        send_request(MODE_SETCUR, 8'h00, 8'hFF, 8'hFF, 8'h00);
        send_request(MODE_DRAW, 8'hFF, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'hFF);
        send_request(MODE_DRAW, 8'h00, 8'd0, 8'd0, 8'h00);
        send_request(MODE_DRAW, 8'h55, 8'd0, 8'(COLUMNS), 8'hAA);
        send_request(MODE_READ, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00);
        send_request(MODE_READ, 8'h00, 8'(ROWS), 8'(COLUMNS - 1), 8'h00);
        send_request(MODE_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(3'd5, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // random: three idle profiles, three register settings each
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                if (chunk == 0)
                    write_console_reg(REG_TEXT_COLOR, 8'h00);
                else if (chunk == 1)
                    write_console_reg(REG_TEXT_COLOR, 8'hFF);
                else
                    write_console_reg(REG_TEXT_COLOR, 8'($urandom));
                write_console_reg(REG_CURSOR_HIDDEN, (chunk == 1) ? 8'h01 : 8'h00);
                if (chunk == 0)
                begin
                    tx_idle_pct <= (phase == 0) ? 24 : (phase == 1) ? 74 : 0;
                    rx_idle_pct <= (phase == 0) ? 74 : (phase == 1) ? 24 : 0;
                end
                // sender runs flat out here, so the hold-off fills the engine
                if (phase == 2 && chunk == 0)
                    hold_start <= 1'b1;
                repeat (CHUNK) send_random_request();
            end
        end

        settle();

        $display("covered %0d put, %0d set cursor, %0d draw, %0d read, %0d clear, %0d unused",
                 mode_count[MODE_PUT], mode_count[MODE_SETCUR], mode_count[MODE_DRAW],
                 mode_count[MODE_READ], mode_count[MODE_CLEAR],
                 mode_count[5] + mode_count[6] + mode_count[7]);
        $display("%0d results checked across %0d register writes, hidden cursor included",
                 checked, settings_used);
        if (errors == 0 && outstanding == 0)
            $display("text_console_engine_top: match");
        else
            $display("text_console_engine_top: mismatch");
        $finish;
    end

endmodule
